@@ design/sog_pkg.sv @@
// Shared types, widths, codes and saturation helpers for the symmetry orbit generator.
// No dependencies; imported by sog_mac and symmetry_orbit_generator.
`timescale 1ns / 1ps

package sog_pkg;

    localparam int COORD_W  = 32;
    localparam int COEF_W   = 18;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int PFLR_W   = PROD_W - FRAC_W;
    localparam int ACC_W    = PFLR_W + 1;
    localparam int FOLD_W   = 7;
    localparam int MAX_FOLD = 64;

    localparam logic [1:0] OP_ROTATE  = 2'd0;
    localparam logic [1:0] OP_REFLECT = 2'd1;
    localparam logic [1:0] OP_INVERT  = 2'd2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0] REG_FOLD_COUNT = 2'd0;
    localparam logic [1:0] REG_ROT_COS    = 2'd1;
    localparam logic [1:0] REG_ROT_SIN    = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Control word from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
        logic sub;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_ROT  = 4'b0100,
        ST_NEG  = 4'b1000
    } seq_state_t;

    function automatic coord_t sat_coord(input acc_t v);
        acc_t hi;
        acc_t lo;
        hi = acc_t'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - acc_t'(1);
        if (v > hi) begin
            return coord_t'(hi[COORD_W-1:0]);
        end else if (v < lo) begin
            return coord_t'(lo[COORD_W-1:0]);
        end
        return coord_t'(v[COORD_W-1:0]);
    endfunction

    function automatic coord_t neg_coord(input coord_t v);
        acc_t wide;
        wide = {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
        return sat_coord(-wide);
    endfunction

endpackage

@@ design/sog_mac.sv @@
// Shared multiply-accumulate unit: coefficient times coordinate, floored to Q16.16,
// summed over two products and saturated. Depends on sog_pkg.
`timescale 1ns / 1ps

module sog_mac
    import sog_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mac_ctrl_t ctrl,
    input  coef_t     coef,
    input  coord_t    operand,
    output coord_t    result
);

    logic signed [PROD_W-1:0] prod_full;
    logic signed [PFLR_W-1:0] prod_reg;
    logic                     pend_reg;
    logic                     first_reg;
    logic                     sub_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    acc_t                     prod_ext;

    assign prod_full = PROD_W'(coef) * PROD_W'(operand);

    // Stage one: register the floored product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctrl.issue;
        end
        prod_reg  <= prod_full[PROD_W-1:FRAC_W];
        first_reg <= ctrl.first;
        sub_reg   <= ctrl.sub;
    end

    assign prod_ext = {prod_reg[PFLR_W-1], prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (pend_reg) begin
            if (first_reg) begin
                acc_next = prod_ext;
            end else if (sub_reg) begin
                acc_next = acc_reg - prod_ext;
            end else begin
                acc_next = acc_reg + prod_ext;
            end
        end
    end

    // Stage two: accumulate
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign result = sat_coord(acc_reg);

endmodule

@@ design/symmetry_orbit_generator.sv @@
// Symmetry orbit generator: accepts a point, operation and axis, emits its orbit.
// Rotated points are computed on the shared multiply-accumulate unit (four products per
// step); pair points are negated directly. A new point is accepted only once the
// previous orbit has been fully handed to the output register; output back-pressure
// stalls the sequence.
// Reset: synchronous active-low aresetn; fold_count 1, cos 1.0, sin 0, output idle.
// Depends on sog_pkg and sog_mac.
`timescale 1ns / 1ps

module symmetry_orbit_generator
    import sog_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Config write port
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [COEF_W-1:0]       cfg_wr_data,
    // Input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*COORD_W-1:0]    s_tdata,   // point_x, point_y, point_z
    input  logic [3:0]              s_tuser,   // operation, axis
    // Output words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [3*COORD_W-1:0]    m_tdata,   // out_x, out_y, out_z
    output logic                    m_tlast
);

    logic [FOLD_W-1:0] fold_reg;
    coef_t             cos_reg;
    coef_t             sin_reg;

    seq_state_t        state_reg, state_next;
    coord_t            point_reg [3];
    logic [1:0]        op_reg;
    logic [1:0]        axis_reg;
    logic [FOLD_W-1:0] left_reg;
    logic [FOLD_W-1:0] left_init;
    logic [2:0]        phase_reg;

    coord_t            out_reg [3];
    logic              out_last_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              do_load;
    logic              s_accept;

    logic [1:0]        u_idx;
    logic [1:0]        v_idx;
    mac_ctrl_t         mac_ctrl;
    coef_t             mac_coef;
    coord_t            mac_operand;
    coord_t            mac_result;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg <= FOLD_W'(1);
            cos_reg  <= coef_t'(65536);
            sin_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FOLD_COUNT: fold_reg <= cfg_wr_data[FOLD_W-1:0];
                REG_ROT_COS:    cos_reg  <= coef_t'(cfg_wr_data);
                REG_ROT_SIN:    sin_reg  <= coef_t'(cfg_wr_data);
                default:        ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign do_load  = (state_reg == ST_LOAD) && out_free;

    always_comb begin
        case (s_tuser[1:0])
            OP_ROTATE: begin
                if (fold_reg == '0) begin
                    left_init = FOLD_W'(1);
                end else if (fold_reg > FOLD_W'(MAX_FOLD)) begin
                    left_init = FOLD_W'(MAX_FOLD);
                end else begin
                    left_init = fold_reg;
                end
            end
            OP_REFLECT, OP_INVERT: left_init = FOLD_W'(2);
            default:               left_init = FOLD_W'(1);
        endcase
    end

    // Rotation plane: u' = c*u - s*v, v' = s*u + c*v
    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                u_idx = 2'd1;
                v_idx = 2'd2;
            end
            AXIS_Y: begin
                u_idx = 2'd2;
                v_idx = 2'd0;
            end
            default: begin
                u_idx = 2'd0;
                v_idx = 2'd1;
            end
        endcase
    end

    always_comb begin
        mac_ctrl    = '0;
        mac_coef    = cos_reg;
        mac_operand = point_reg[u_idx];
        if (state_reg == ST_ROT) begin
            case (phase_reg)
                3'd0: begin
                    mac_ctrl    = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
                    mac_coef    = cos_reg;
                    mac_operand = point_reg[u_idx];
                end
                3'd1: begin
                    mac_ctrl    = '{issue: 1'b1, first: 1'b0, sub: 1'b1};
                    mac_coef    = sin_reg;
                    mac_operand = point_reg[v_idx];
                end
                3'd2: begin
                    mac_ctrl    = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
                    mac_coef    = sin_reg;
                    mac_operand = point_reg[u_idx];
                end
                3'd3: begin
                    mac_ctrl    = '{issue: 1'b1, first: 1'b0, sub: 1'b0};
                    mac_coef    = cos_reg;
                    mac_operand = point_reg[v_idx];
                end
                default: ;
            endcase
        end
    end

    sog_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .result  (mac_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (left_reg == FOLD_W'(1)) begin
                        state_next = ST_IDLE;
                    end else if (op_reg != OP_ROTATE) begin
                        state_next = ST_NEG;
                    end else if (axis_reg != AXIS_NONE) begin
                        state_next = ST_ROT;
                    end
                end
            end
            ST_ROT: begin
                if (phase_reg == 3'd5) begin
                    state_next = ST_LOAD;
                end
            end
            ST_NEG:  state_next = ST_LOAD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ROT) begin
                phase_reg <= phase_reg + 3'd1;
            end else begin
                phase_reg <= '0;
            end
            if (s_accept) begin
                left_reg <= left_init;
            end else if (do_load) begin
                left_reg <= left_reg - FOLD_W'(1);
            end
            if (do_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Point registers and output word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_tuser[1:0];
            axis_reg     <= s_tuser[3:2];
            point_reg[0] <= coord_t'(s_tdata[COORD_W-1:0]);
            point_reg[1] <= coord_t'(s_tdata[2*COORD_W-1:COORD_W]);
            point_reg[2] <= coord_t'(s_tdata[3*COORD_W-1:2*COORD_W]);
        end else if (state_reg == ST_ROT) begin
            if (phase_reg == 3'd3) begin
                point_reg[u_idx] <= mac_result;
            end else if (phase_reg == 3'd5) begin
                point_reg[v_idx] <= mac_result;
            end
        end else if (state_reg == ST_NEG) begin
            for (int i = 0; i < 3; i++) begin
                if (op_reg == OP_INVERT || axis_reg == AXIS_NONE || axis_reg == 2'(i)) begin
                    point_reg[i] <= neg_coord(point_reg[i]);
                end
            end
        end
        if (do_load) begin
            out_reg[0]   <= point_reg[0];
            out_reg[1]   <= point_reg[1];
            out_reg[2]   <= point_reg[2];
            out_last_reg <= (left_reg == FOLD_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for symmetry_orbit_generator: drives points and register writes,
// predicts every orbit word in a small scoreboard class and compares on the result stream.
// Depends on sog_pkg and the symmetry_orbit_generator RTL.
`timescale 1ns / 1ps

module testbench;
    import sog_pkg::*;

    localparam logic [1:0] OP_PASS    = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam coord_t     COORD_MAX  = 32'sh7FFF_FFFF;
    localparam coord_t     COORD_MIN  = 32'sh8000_0000;
    localparam int         NUM_ITEMS  = 270;

    typedef struct {
        coord_t pt[3];
        logic   last;
    } orbit_word_t;

    class orbit_scoreboard;
        logic [FOLD_W-1:0]  fold_reg;
        logic signed [17:0] cos_reg;
        logic signed [17:0] sin_reg;
        coord_t             cur[3];
        orbit_word_t        expected_points[$];
        int                 errors;

        function new();
            fold_reg = 7'd1;
            cos_reg  = 18'sd65536;
            sin_reg  = 18'sd0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [COEF_W-1:0] val);
            case (idx)
                REG_FOLD_COUNT: fold_reg = val[FOLD_W-1:0];
                REG_ROT_COS:    cos_reg  = val;
                REG_ROT_SIN:    sin_reg  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // floor(coef * a / 2^16)
        function longint scaled_product(longint coef, longint a);
            return (coef * a) >>> 16;
        endfunction

        function coord_t clamp(longint v);
            if (v > longint'(COORD_MAX)) return COORD_MAX;
            if (v < longint'(COORD_MIN)) return COORD_MIN;
            return coord_t'(v);
        endfunction

        function void rotate_about(logic [1:0] axis);
            longint c, s, x, y, z;
            c = longint'(cos_reg);
            s = longint'(sin_reg);
            x = longint'(cur[0]);
            y = longint'(cur[1]);
            z = longint'(cur[2]);
            case (axis)
                AXIS_X: begin
                    cur[1] = clamp(scaled_product(c, y) - scaled_product(s, z));
                    cur[2] = clamp(scaled_product(s, y) + scaled_product(c, z));
                end
                AXIS_Y: begin
                    cur[0] = clamp(scaled_product(c, x) + scaled_product(s, z));
                    cur[2] = clamp(scaled_product(c, z) - scaled_product(s, x));
                end
                AXIS_Z: begin
                    cur[0] = clamp(scaled_product(c, x) - scaled_product(s, y));
                    cur[1] = clamp(scaled_product(s, x) + scaled_product(c, y));
                end
                default: ;
            endcase
        endfunction

        function void push_point(logic last);
            orbit_word_t w;
            w.pt   = cur;
            w.last = last;
            expected_points.insert(expected_points.size(), w);
        endfunction

        function void note_input(logic [1:0] op, logic [1:0] axis, coord_t x, coord_t y,
                                 coord_t z);
            int n;
            cur[0] = x;
            cur[1] = y;
            cur[2] = z;
            if (op == OP_ROTATE) begin
                n = int'(fold_reg);
                if (n == 0) n = 1;
                if (n > MAX_FOLD) n = MAX_FOLD;
                for (int k = 0; k < n; k++) begin
                    push_point(k == n - 1);
                    if (k < n - 1) rotate_about(axis);
                end
            end else if (op == OP_REFLECT || op == OP_INVERT) begin
                push_point(1'b0);
                // mirror with no normal axis falls back to inversion
                for (int i = 0; i < 3; i++) begin
                    if (op == OP_INVERT || axis == AXIS_NONE || i == axis)
                        cur[i] = clamp(-longint'(cur[i]));
                end
                push_point(1'b1);
            end else begin
                push_point(1'b1);
            end
        endfunction

        function void check_output(logic [3*COORD_W-1:0] data, logic last);
            orbit_word_t w;
            coord_t      got;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected word, got %h last %b", $time, data, last);
                errors++;
                return;
            end
            w = expected_points.pop_front();
            for (int i = 0; i < 3; i++) begin
                got = data[i*COORD_W +: COORD_W];
                if (got !== w.pt[i]) begin
                    $display("%0t: coordinate %0d expected %h, got %h", $time, i, w.pt[i], got);
                    errors++;
                end
            end
            if (last !== w.last) begin
                $display("%0t: last_point expected %b, got %b", $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [1:0]           cfg_index   = '0;
    logic [COEF_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [3*COORD_W-1:0] s_tdata     = '0;
    logic [3:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [3*COORD_W-1:0] m_tdata;
    logic                 m_tlast;

    orbit_scoreboard sb = new();
    int send_idle_pct = 6;
    int recv_idle_pct = 69;
    int items_sent    = 0;

    symmetry_orbit_generator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_output(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold valid across back-to-back words; lower it only on an idle cycle.
    task automatic send_item(input logic [1:0] op, input logic [1:0] axis,
                             input coord_t x, input coord_t y, input coord_t z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= {axis, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, axis, x, y, z);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Write all three registers, then junk to the unused index.
    task automatic program_regs(input logic [COEF_W-1:0] fold, input logic [COEF_W-1:0] c,
                                input logic [COEF_W-1:0] s);
        logic [COEF_W-1:0] junk;
        junk = COEF_W'($urandom);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FOLD_COUNT;
        cfg_wr_data <= fold;
        @(posedge aclk);
        sb.write_reg(REG_FOLD_COUNT, fold);
        cfg_index   <= REG_ROT_COS;
        cfg_wr_data <= c;
        @(posedge aclk);
        sb.write_reg(REG_ROT_COS, c);
        cfg_index   <= REG_ROT_SIN;
        cfg_wr_data <= s;
        @(posedge aclk);
        sb.write_reg(REG_ROT_SIN, s);
        cfg_index   <= REG_UNUSED;
        cfg_wr_data <= junk;
        @(posedge aclk);
        sb.write_reg(REG_UNUSED, junk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [COEF_W-1:0] pick_extreme_coef();
        case ($urandom_range(4))
            0:       return 18'sd65536;
            1:       return -18'sd65536;
            2:       return 18'sd131071;
            3:       return 18'sh20000;
            default: return 18'sd0;
        endcase
    endfunction

    task automatic program_random();
        logic [COEF_W-1:0]         fold;
        logic signed [COEF_W-1:0]  c;
        logic signed [COEF_W-1:0]  s;
        int                        t;
        t = $urandom_range(99);
        if (t < 70) fold = COEF_W'($urandom_range(1, 8));
        else if (t < 85) fold = COEF_W'($urandom_range(9, 20));
        else if (t < 95) begin
            case ($urandom_range(5))
                0: fold = 18'd0;
                1: fold = 18'd1;
                2: fold = 18'd63;
                3: fold = 18'd64;
                4: fold = 18'd65;
                default: fold = 18'd127;
            endcase
        end else fold = COEF_W'($urandom);
        // upper bits of the fold write are don't-care
        if ($urandom_range(3) == 0) fold[COEF_W-1:FOLD_W] = (COEF_W-FOLD_W)'($urandom);
        t = $urandom_range(9);
        if (t < 6) begin
            case ($urandom_range(5))
                0: begin c = 18'sd65536;  s = 18'sd0;     end
                1: begin c = -18'sd65536; s = 18'sd0;     end
                2: begin c = -18'sd32768; s = 18'sd56756; end
                3: begin c = 18'sd0;      s = 18'sd65536; end
                4: begin c = 18'sd32768;  s = 18'sd56756; end
                default: begin c = 18'sd46341; s = 18'sd46341; end
            endcase
            if ($urandom_range(1)) s = -s;
        end else if (t < 8) begin
            c = COEF_W'($urandom);
            s = COEF_W'($urandom);
        end else begin
            c = pick_extreme_coef();
            s = pick_extreme_coef();
        end
        program_regs(fold, c, s);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5, 6: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 1310720)) - 655360);
        endcase
    endfunction

    task automatic send_random_item();
        logic [1:0] op;
        int         t;
        t = $urandom_range(9);
        if (t < 5) op = OP_ROTATE;
        else if (t < 7) op = OP_REFLECT;
        else if (t < 9) op = OP_INVERT;
        else op = OP_PASS;
        send_item(op, 2'($urandom_range(3)), pick_coord(), pick_coord(), pick_coord());
    endtask

    initial begin
        int directed;
        int burst;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: single-point rotation orbit
        send_item(OP_ROTATE, AXIS_X, 32'sd0, 32'sd0, 32'sd0);
        send_item(OP_ROTATE, AXIS_NONE, COORD_MAX, COORD_MIN, -32'sd1);
        send_item(OP_REFLECT, AXIS_X, COORD_MIN, COORD_MAX, 32'sd65536);
        send_item(OP_REFLECT, AXIS_Y, 32'sd12345, COORD_MIN, -32'sd98765);
        send_item(OP_REFLECT, AXIS_Z, -32'sd1, 32'sd7, COORD_MIN);
        send_item(OP_REFLECT, AXIS_NONE, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(OP_INVERT, AXIS_Z, COORD_MIN, COORD_MAX, 32'sd0);
        send_item(OP_PASS, AXIS_Y, COORD_MAX, -32'sd3, COORD_MIN);
        drain();

        // quarter turn about every axis, and with axis none
        program_regs(18'd4, 18'sd0, 18'sd65536);
        for (int a = 0; a < 4; a++)
            send_item(2'(OP_ROTATE), 2'(a), 32'sd65536, 32'sd131072, -32'sd196608);
        drain();
        program_regs(18'd0, -18'sd65536, 18'sd0);
        send_item(OP_ROTATE, AXIS_Z, 32'sd100, 32'sd200, 32'sd300);
        drain();
        program_regs(18'd64, 18'sd65220, 18'sd6424);
        send_item(OP_ROTATE, AXIS_Z, 32'sd10 <<< 16, -32'sd3 <<< 16, 32'sd1);
        drain();
        // fold above the maximum, coefficients out of range: saturation
        program_regs(18'h3FFFF, 18'sd131071, 18'sh20000);
        send_item(OP_ROTATE, AXIS_Y, COORD_MAX, 32'sd5, COORD_MIN);
        drain();
        program_regs(18'd3, -18'sd65536, 18'sd65536);
        send_item(OP_ROTATE, AXIS_X, 32'sd1, COORD_MAX, COORD_MAX);
        drain();

        directed = items_sent;
        while (items_sent < NUM_ITEMS) begin
            if (items_sent - directed < (NUM_ITEMS - directed) / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 69;
            end else if (items_sent - directed < 2 * (NUM_ITEMS - directed) / 3) begin
                send_idle_pct = 69;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_random();
            burst = $urandom_range(5, 20);
            repeat (burst) send_random_item();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
